// ===== rtl/core/work_stealing_task_queues_assert.svh =====
// Assertion macros used by the work-stealing queue RTL
`ifndef WORK_STEALING_TASK_QUEUES_ASSERT_SVH
`define WORK_STEALING_TASK_QUEUES_ASSERT_SVH

// Implication checked on every rising clock edge, off during reset
`define WSTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define WSTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wstq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstq_pkg
// Shared command codes and payload types of the work-stealing task queues.
// ----------------------------------------------------------------------------
package wstq_pkg;

    localparam logic [1:0] CMD_EXT_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_WRK_SUBMIT = 2'd1;
    localparam logic [1:0] CMD_FETCH      = 2'd2;
    localparam logic [1:0] CMD_COMPLETE   = 2'd3;

    localparam int unsigned ACTIVE_W   = 14;
    localparam logic [13:0] ACTIVE_MAX = 14'd16383;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  worker;
        logic [31:0] task_handle;
        logic [14:0] steal_draws;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] task_out;
        logic        stolen;
        logic [2:0]  queue_used;
        logic [2:0]  steal_tries;
        logic [13:0] active_count;
        logic        all_done;
    } out_item_t;

endpackage

// ===== rtl/core/wstq_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstq_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface wstq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/work_stealing_task_queues.sv =====
`timescale 1ns / 1ps
// One command per transfer, one result per command. A submit passes through
// reduction, queue check with store write and result, with a second queue
// check when a worker submit falls over to the next queue; a completion
// passes through reduction and result; a fetch from the own queue passes
// through reduction, pop, store read and result, and each steal try adds a
// victim reduction, a self skip and a queue check, up to five tries. The
// shared modulo unit subtracts the worker count once per cycle, up to 7
// subtractions per reduction with a single worker. The result is held in an
// output register, and the next command is accepted once that result has
// been taken.
// ----------------------------------------------------------------------------
// work_stealing_task_queues
// Per-worker circular task queues with round-robin submit and work stealing.
// ----------------------------------------------------------------------------
module work_stealing_task_queues #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 1024,
    parameter int STEAL_TRIES = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    wstq_stream_if.sink         in_ch,
    wstq_stream_if.source       out_ch
);
    import wstq_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = QW + PW;
    localparam int TW = $clog2(STEAL_TRIES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_PUSH  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_VIC   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_VMOD  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] wc_cfg_reg;
    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [PW-1:0] tail_reg [NUM_QUEUES];
    logic [CW-1:0] fill_reg [NUM_QUEUES];
    logic [3:0]  rr_reg;
    logic [13:0] active_reg;
    in_item_t    item_reg;
    out_item_t   res_reg;
    logic        out_valid_reg;
    logic [3:0]  q_reg;       // queue under work
    logic [3:0]  self_reg;
    logic        second_reg;  // worker submit fell over to next queue
    logic [TW-1:0] try_reg;

    // effective worker count, clamped to 1..NUM_QUEUES
    logic [3:0] wc;
    always_comb
    begin
        if (wc_cfg_reg == 4'd0)
        begin
            wc = 4'd1;
        end
        else if (32'(wc_cfg_reg) > NUM_QUEUES)
        begin
            wc = 4'(NUM_QUEUES);
        end
        else
        begin
            wc = wc_cfg_reg;
        end
    end

    // shared reduction unit: value below 16 mod wc, one compare-subtract step
    logic [3:0] mod_a, mod_y;
    always_comb
    begin
        mod_y = (mod_a >= wc) ? mod_a - wc : mod_a;
    end
    logic mod_done;
    assign mod_done = (mod_a < wc);

    // draw for the current try
    logic [2:0] draw;
    always_comb
    begin
        if (32'(try_reg) < 5)
        begin
            draw = item_reg.steal_draws[3*try_reg +: 3];
        end
        else
        begin
            draw = 3'd0;
        end
    end

    logic [QW-1:0] qi;
    assign qi = q_reg[QW-1:0];
    logic full_q, empty_q;
    assign full_q  = (fill_reg[qi] == CW'(QUEUE_DEPTH));
    assign empty_q = (fill_reg[qi] == '0);

    // store port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    wstq_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_store (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(item_reg.task_handle),
        .rdata(ram_rdata)
    );
    always_comb
    begin
        ram_we = (state_reg == S_PUSH) && !full_q;
        if (state_reg == S_PUSH)
        begin
            ram_addr = AW'({qi, tail_reg[qi]});
        end
        else
        begin
            ram_addr = AW'({qi, head_reg[qi]});
        end
    end

    assign in_ch.ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = res_reg;

    always_comb
    begin
        state_next = state_reg;
        mod_a = q_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid && in_ch.ready) state_next = S_MOD;
            S_MOD:
            begin
                if (mod_done)
                begin
                    if (item_reg.cmd == CMD_FETCH) state_next = S_POP;
                    else if (item_reg.cmd == CMD_COMPLETE) state_next = S_OUT;
                    else state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!full_q || item_reg.cmd == CMD_EXT_SUBMIT || second_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_POP:   state_next = empty_q ? ((try_reg == TW'(STEAL_TRIES)) ? S_OUT : S_VMOD)
                                          : S_RD;
            S_VMOD:  if (mod_done) state_next = S_VIC;
            S_VIC:   state_next = S_POP;
            S_RD:    state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wc_cfg_reg    <= 4'd8;
            rr_reg        <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) wc_cfg_reg <= cfg_wdata;
            if (out_ch.valid && out_ch.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg   <= in_ch.payload;
                        q_reg      <= (in_ch.payload.cmd == CMD_EXT_SUBMIT)
                                      ? rr_reg : {1'b0, in_ch.payload.worker};
                        second_reg <= 1'b0;
                        try_reg    <= '0;
                        res_reg    <= '0;
                    end
                end
                S_MOD:
                begin
                    q_reg <= mod_y;
                    if (mod_done)
                    begin
                        self_reg <= q_reg;
                        res_reg.queue_used <= q_reg[2:0];
                        if (item_reg.cmd == CMD_EXT_SUBMIT)
                        begin
                            rr_reg <= (q_reg + 4'd1 == wc) ? 4'd0 : q_reg + 4'd1;
                        end
                    end
                end
                S_PUSH:
                begin
                    res_reg.queue_used <= q_reg[2:0];
                    if (!full_q)
                    begin
                        tail_reg[qi] <= (tail_reg[qi] == PW'(QUEUE_DEPTH - 1))
                                        ? '0 : tail_reg[qi] + 1'b1;
                        fill_reg[qi] <= fill_reg[qi] + 1'b1;
                        res_reg.ok   <= 1'b1;
                        if (active_reg != ACTIVE_MAX) active_reg <= active_reg + 1'b1;
                    end
                    else if (item_reg.cmd == CMD_WRK_SUBMIT && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        q_reg <= (q_reg + 4'd1 == wc) ? 4'd0 : q_reg + 4'd1;
                    end
                end
                S_POP:
                begin
                    if (!empty_q)
                    begin
                        head_reg[qi] <= (head_reg[qi] == PW'(QUEUE_DEPTH - 1))
                                        ? '0 : head_reg[qi] + 1'b1;
                        fill_reg[qi] <= fill_reg[qi] - 1'b1;
                        res_reg.ok   <= 1'b1;
                        res_reg.queue_used <= q_reg[2:0];
                        res_reg.stolen <= (q_reg != self_reg);
                    end
                    else if (try_reg != TW'(STEAL_TRIES))
                    begin
                        q_reg <= {1'b0, draw};
                    end
                end
                S_VMOD:
                begin
                    q_reg <= mod_y;
                end
                S_VIC:
                begin
                    try_reg <= try_reg + 1'b1;
                    res_reg.steal_tries <= 3'(try_reg + 1'b1);
                    if (q_reg == self_reg)
                    begin
                        q_reg <= (q_reg + 4'd1 == wc) ? 4'd0 : q_reg + 4'd1;
                    end
                end
                S_RD:
                begin
                    // read data of the head addressed during the pop
                    res_reg.task_out <= ram_rdata;
                end
                S_OUT:
                begin
                    if (item_reg.cmd == CMD_COMPLETE
                        || (item_reg.cmd == CMD_FETCH && !res_reg.ok))
                    begin
                        res_reg.queue_used <= 3'd0;
                    end
                    if (item_reg.cmd == CMD_COMPLETE)
                    begin
                        if (active_reg != '0)
                        begin
                            active_reg <= active_reg - 1'b1;
                            res_reg.all_done <= (active_reg == 14'd1);
                            res_reg.active_count <= active_reg - 1'b1;
                        end
                        else
                        begin
                            res_reg.active_count <= active_reg;
                        end
                    end
                    else
                    begin
                        res_reg.active_count <= active_reg;
                    end
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `include "work_stealing_task_queues_assert.svh"
    `WSTQ_ASSERT_IMP(a_busy_not_ready, state_reg != S_IDLE, !in_ch.ready, "ready while busy")
    `WSTQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg[qi] <= CW'(QUEUE_DEPTH), "fill over depth")
    `WSTQ_ASSERT_NEXT(a_out_follows, state_reg == S_OUT, out_valid_reg, "no result after S_OUT")
    `WSTQ_ASSERT_IMP(a_tries_bound, 1'b1, 32'(try_reg) <= STEAL_TRIES, "too many steal tries")
endmodule

// ===== rtl/core/wstq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the work-stealing task queues against a cycle-free predictor: each
// accepted command is scored into an expected result, and every result
// transfer is compared field by field. The stimulus has a directed part, a
// single-worker part with self steals, and random traffic under several
// worker counts. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
    import wstq_pkg::*;

    localparam int NQ        = 8;
    localparam int QDEPTH    = 1024;
    localparam int TRIES     = 5;
    localparam int WDOG_MAX  = 2000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    wstq_stream_if #(.payload_t(in_item_t))  in_ch ();
    wstq_stream_if #(.payload_t(out_item_t)) out_ch ();

    work_stealing_task_queues uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state
    logic [31:0] task_mem [NQ][QDEPTH];
    int unsigned head_q [NQ];
    int unsigned tail_q [NQ];
    int unsigned fill_q [NQ];
    int unsigned rr_next;
    int unsigned busy_count;
    logic [3:0]  wcount_reg;

    in_item_t  cmd_pending [$];
    out_item_t result_due [$];
    int        mismatches;
    bit        calm;
    int        drv_gap;
    int        mon_gap;
    int        stall_count;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit push_task(int unsigned q, logic [31:0] t);
        if (fill_q[q] >= QDEPTH)
            return 1'b0;
        task_mem[q][tail_q[q]] = t;
        tail_q[q] = (tail_q[q] + 1) % QDEPTH;
        fill_q[q]++;
        return 1'b1;
    endfunction

    function automatic bit pop_task(int unsigned q, output logic [31:0] t);
        t = '0;
        if (fill_q[q] == 0)
            return 1'b0;
        t = task_mem[q][head_q[q]];
        head_q[q] = (head_q[q] + 1) % QDEPTH;
        fill_q[q]--;
        return 1'b1;
    endfunction

    // Scores one command and updates the predicted queue state
    function automatic out_item_t schedule_step(in_item_t it);
        int unsigned wc;
        int unsigned self_q;
        int unsigned victim;
        logic [31:0] t;
        out_item_t   r;
        r = '0;
        wc = (wcount_reg == 0) ? 1 : ((wcount_reg > NQ) ? NQ : wcount_reg);
        self_q = it.worker % wc;
        case (it.cmd)
            CMD_EXT_SUBMIT:
            begin
                victim = rr_next % wc;
                rr_next = (victim + 1) % wc;
                r.queue_used = 3'(victim);
                r.ok = push_task(victim, it.task_handle);
                if (r.ok && busy_count < ACTIVE_MAX)
                    busy_count++;
            end
            CMD_WRK_SUBMIT:
            begin
                r.queue_used = 3'(self_q);
                r.ok = push_task(self_q, it.task_handle);
                if (!r.ok)
                begin
                    r.queue_used = 3'((self_q + 1) % wc);
                    r.ok = push_task((self_q + 1) % wc, it.task_handle);
                end
                if (r.ok && busy_count < ACTIVE_MAX)
                    busy_count++;
            end
            CMD_FETCH:
            begin
                if (pop_task(self_q, t))
                begin
                    r.ok = 1'b1;
                    r.task_out = t;
                    r.queue_used = 3'(self_q);
                end
                else
                begin
                    for (int a = 0; a < TRIES; a++)
                    begin
                        victim = ((it.steal_draws >> (3 * a)) & 3'h7) % wc;
                        if (victim == self_q)
                            victim = (victim + 1) % wc;
                        r.steal_tries++;
                        if (pop_task(victim, t))
                        begin
                            r.ok = 1'b1;
                            r.task_out = t;
                            r.queue_used = 3'(victim);
                            r.stolen = (victim != self_q);
                            break;
                        end
                    end
                end
            end
            default:
            begin
                if (busy_count > 0)
                begin
                    busy_count--;
                    r.all_done = (busy_count == 0);
                end
            end
        endcase
        r.active_count = 14'(busy_count);
        return r;
    endfunction

    task automatic add_cmd(logic [1:0] c, logic [2:0] w, logic [31:0] h, logic [14:0] d);
        in_item_t it;
        it.cmd = c;
        it.worker = w;
        it.task_handle = h;
        it.steal_draws = d;
        cmd_pending.push_back(it);
    endtask

    // Random traffic: submits dominate so the queues build up and steals hit
    task automatic add_random(int n);
        int unsigned pick;
        logic [1:0]  c;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                c = CMD_EXT_SUBMIT;
            else if (pick < 50)
                c = CMD_WRK_SUBMIT;
            else if (pick < 80)
                c = CMD_FETCH;
            else
                c = CMD_COMPLETE;
            add_cmd(c, 3'($urandom_range(0, 7)), $urandom, 15'($urandom_range(0, 32767)));
        end
    endtask

    // Sampled at the falling edge, where driver and monitor updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (cmd_pending.size() != 0 || result_due.size() != 0 || in_ch.valid)
            @(negedge clk);
    endtask

    task automatic write_wcount(logic [3:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        wcount_reg = v;
    endtask

    // Command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
            drv_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                result_due.push_back(schedule_step(in_ch.payload));
            if (in_ch.valid && !in_ch.ready)
            begin
                // hold the current item
            end
            else if (drv_gap > 0)
            begin
                drv_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (cmd_pending.size() != 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                drv_gap = $urandom_range(1, 10) - 1;
                in_ch.valid <= 1'b0;
            end
            else if (cmd_pending.size() != 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= cmd_pending.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            mon_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (result_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = result_due.pop_front();
                    if (got.ok !== want.ok || got.task_out !== want.task_out
                        || got.stolen !== want.stolen || got.queue_used !== want.queue_used
                        || got.steal_tries !== want.steal_tries
                        || got.active_count !== want.active_count
                        || got.all_done !== want.all_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (mon_gap > 0)
            begin
                mon_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                mon_gap = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WDOG_MAX)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        wcount_reg = 4'd8;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full worker count, empty queues
        write_wcount(4'd8);
        add_cmd(CMD_COMPLETE, 3'd0, 32'h0, 15'h0);            // completion at zero
        add_cmd(CMD_FETCH, 3'd3, 32'h0, 15'h0);               // all steals fail
        add_cmd(CMD_FETCH, 3'd7, 32'h0, 15'h7fff);
        add_cmd(CMD_EXT_SUBMIT, 3'd0, 32'hffff_ffff, 15'h0);
        add_cmd(CMD_EXT_SUBMIT, 3'd5, 32'h0000_0000, 15'h7fff);
        add_cmd(CMD_EXT_SUBMIT, 3'd2, 32'ha5a5_a5a5, 15'h0);
        add_cmd(CMD_WRK_SUBMIT, 3'd7, 32'h5a5a_5a5a, 15'h0);
        add_cmd(CMD_FETCH, 3'd0, 32'h0, 15'h0);               // own queue
        add_cmd(CMD_FETCH, 3'd2, 32'h0, 15'h000a);            // own queue holds a task, no steal
        add_cmd(CMD_FETCH, 3'd5, 32'h0, 15'h0007);            // steal from queue 7
        add_cmd(CMD_FETCH, 3'd6, 32'h0, 15'h2492);
        repeat (5) add_cmd(CMD_COMPLETE, 3'd4, 32'h0, 15'h0); // down to zero, then past it

        // Single worker: self steal, submits and fetch on the only queue
        write_wcount(4'd1);
        add_cmd(CMD_FETCH, 3'd5, 32'h0, 15'h7fff);
        add_cmd(CMD_WRK_SUBMIT, 3'd3, 32'h1234_5678, 15'h0);
        add_cmd(CMD_FETCH, 3'd6, 32'h0, 15'h5555);
        add_cmd(CMD_WRK_SUBMIT, 3'd6, 32'h8765_4321, 15'h0);

        // Random phases over several worker counts
        write_wcount(4'd0);
        add_random(80);
        write_wcount(4'd15);
        add_random(150);
        write_wcount(4'd3);
        add_random(120);
        write_wcount(4'd5);
        add_random(100);
        write_wcount(4'd8);
        calm = 1'b1;
        add_random(130);

        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && result_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wstq_pkg.sv
rtl/core/wstq_stream_if.sv
rtl/core/wstq_ram.sv
rtl/core/work_stealing_task_queues.sv
bench/tb_top.sv
